// ===== design/sia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sia_pkg: shared types and codes of the stack machine integer ALU
// Opcodes, status codes and the beat structs of both channels.
// ----------------------------------------------------------------------------
package sia_pkg;

	localparam logic [4:0] OP_PUSH   = 5'd0;
	localparam logic [4:0] OP_ADD    = 5'd1;
	localparam logic [4:0] OP_SUB    = 5'd2;
	localparam logic [4:0] OP_DIV    = 5'd3;
	localparam logic [4:0] OP_MUL    = 5'd4;
	localparam logic [4:0] OP_AND    = 5'd5;
	localparam logic [4:0] OP_OR     = 5'd6;
	localparam logic [4:0] OP_XOR    = 5'd7;
	localparam logic [4:0] OP_NOT    = 5'd8;
	localparam logic [4:0] OP_LSHIFT = 5'd9;
	localparam logic [4:0] OP_RSHIFT = 5'd10;
	localparam logic [4:0] UNSIGNED_BASE = 5'd11;
	localparam logic [4:0] LAST_OPCODE   = 5'd21;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_UNDER = 2'd1;
	localparam logic [1:0] ST_OVER  = 2'd2;
	localparam logic [1:0] ST_DIVZ  = 2'd3;

	typedef struct packed {
		logic [4:0]  kind;
		logic [31:0] immediate;
	} sia_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] top_value;
		logic [8:0]  stack_depth;
	} sia_out_t;

endpackage

// ===== design/stack_integer_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_integer_alu: integer stack machine ALU
// Executes one stack instruction per beat on an operand stack held in a RAM.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_data) carries one instruction per
// beat: an opcode and a 32-bit immediate. The output channel (out_valid,
// out_stall, out_data) returns one beat per instruction with the status, the
// low 32 bits of the new top word and the stack depth.
// The block works on one instruction at a time. A push, an undefined opcode
// or a failed depth check goes straight to the output state, and NOT first
// writes the complemented top word back. For a binary operation the top word
// is kept in a register and the second operand is read from the RAM (a read
// state, then a capture state); then come an execute, a write-back and an
// output state. Multiply adds a state for its registered product, and a zero
// divisor goes from the execute state straight to the output state. Division
// runs a restoring divider that retires one quotient bit per cycle. The
// result sits in an output register; while the receiver stalls, it holds,
// and the next instruction is accepted in the cycle after the beat is taken.
// Reset (arst_n low) empties the stack; the stack RAM itself is not cleared.
// ----------------------------------------------------------------------------
module stack_integer_alu
	import sia_pkg::*;
#(
	parameter int WORD_WIDTH  = 32,
	parameter int STACK_DEPTH = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  sia_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output sia_out_t out_data
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int PW = $clog2(STACK_DEPTH + 1);
	localparam int CW = $clog2(WORD_WIDTH + 1);
	localparam int NW = (WORD_WIDTH > 32) ? WORD_WIDTH : 32;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RD_A  = 3'd1;
	localparam logic [2:0] S_RD_B  = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_MUL   = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_WB    = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	logic [WORD_WIDTH-1:0] stack_mem [STACK_DEPTH];
	logic [WORD_WIDTH-1:0] rd_data_q;
	logic                  mem_we;
	logic [AW-1:0]         mem_waddr;
	logic [WORD_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [AW-1:0]         mem_raddr;

	logic [2:0]            state_q;
	logic [PW-1:0]         sp_q;
	logic [WORD_WIDTH-1:0] top_q;
	logic [3:0]            op_q;
	logic                  sgn_q;
	logic [WORD_WIDTH-1:0] a_q;
	logic [WORD_WIDTH-1:0] b_q;
	logic [WORD_WIDTH-1:0] res_q;
	logic [WORD_WIDTH-1:0] prod_q;
	logic [WORD_WIDTH-1:0] quo_q;
	logic [WORD_WIDTH-1:0] rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	logic                  out_valid_q;
	sia_out_t              out_q;

	// Decode of the accepted instruction.
	logic       in_fire;
	logic       dec_valid;
	logic       dec_sgn;
	logic [3:0] dec_op;
	logic [4:0] dec_raw;

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		dec_valid = in_data.kind <= LAST_OPCODE;
		dec_sgn   = in_data.kind < UNSIGNED_BASE;
		dec_raw   = dec_sgn ? in_data.kind : in_data.kind - UNSIGNED_BASE;
		dec_op    = dec_raw[3:0];
	end

	// Immediate extended to the word width.
	logic [NW-1:0] imm_ext;
	always_comb begin
		imm_ext = NW'(in_data.immediate);
		if (dec_sgn) begin
			imm_ext = NW'($signed(in_data.immediate));
		end
	end

	// Execute-stage combinational result for the operations other than multiply and divide.
	logic [WORD_WIDTH-1:0] alu_res;
	logic                  big_shift;
	logic [CW-1:0]         shamt;
	always_comb begin
		big_shift = b_q >= WORD_WIDTH'(WORD_WIDTH);
		shamt     = b_q[CW-1:0];
		case (op_q)
			OP_ADD[3:0]:    alu_res = a_q + b_q;
			OP_SUB[3:0]:    alu_res = a_q - b_q;
			OP_AND[3:0]:    alu_res = a_q & b_q;
			OP_OR[3:0]:     alu_res = a_q | b_q;
			OP_XOR[3:0]:    alu_res = a_q ^ b_q;
			OP_LSHIFT[3:0]: alu_res = big_shift ? '0 : a_q << shamt;
			OP_RSHIFT[3:0]: begin
				if (sgn_q) begin
					alu_res = big_shift ? {WORD_WIDTH{a_q[WORD_WIDTH-1]}}
						: WORD_WIDTH'($signed(a_q) >>> shamt);
				end else begin
					alu_res = big_shift ? '0 : a_q >> shamt;
				end
			end
			default:        alu_res = '0;
		endcase
	end

	// Magnitudes for the divider.
	logic [WORD_WIDTH-1:0] mag_a, mag_b;
	assign mag_a = (sgn_q && a_q[WORD_WIDTH-1]) ? -a_q : a_q;
	assign mag_b = (sgn_q && b_q[WORD_WIDTH-1]) ? -b_q : b_q;

	// One restoring division step.
	logic [WORD_WIDTH:0]   div_trial;
	logic [WORD_WIDTH-1:0] div_shift;
	assign div_shift = {rem_q[WORD_WIDTH-2:0], quo_q[WORD_WIDTH-1]};
	assign div_trial = {rem_q[WORD_WIDTH-1], div_shift} - {1'b0, b_q};

	// Stack RAM: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= stack_mem[mem_raddr];
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = '0;
		if (state_q == S_RD_A) begin
			mem_re    = 1'b1;
			mem_raddr = AW'(sp_q - PW'(2));
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(sp_q - PW'(1));
		mem_wdata = top_q;
		if (in_fire && dec_valid && dec_op == OP_PUSH[3:0] && sp_q != PW'(STACK_DEPTH)) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(sp_q);
			mem_wdata = imm_ext[WORD_WIDTH-1:0];
		end else if (state_q == S_WB) begin
			mem_we    = 1'b1;
			mem_wdata = res_q;
		end
	end

	// The result beat reports the low 32 bits of the top word.
	function automatic logic [31:0] low32(input logic [WORD_WIDTH-1:0] w);
		logic [NW-1:0] x;
		x = NW'(w);
		return x[31:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sp_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q  <= dec_op;
						sgn_q <= dec_sgn;
						out_q.status <= ST_OK;
						if (!dec_valid) begin
							state_q <= S_OUT;
						end else if (dec_op == OP_PUSH[3:0]) begin
							if (sp_q == PW'(STACK_DEPTH)) begin
								out_q.status <= ST_OVER;
							end else begin
								sp_q  <= sp_q + PW'(1);
								top_q <= imm_ext[WORD_WIDTH-1:0];
							end
							state_q <= S_OUT;
						end else if (dec_op == OP_NOT[3:0]) begin
							if (sp_q == '0) begin
								out_q.status <= ST_UNDER;
								state_q <= S_OUT;
							end else begin
								res_q   <= ~top_q;
								state_q <= S_WB;
							end
						end else if (sp_q < PW'(2)) begin
							out_q.status <= ST_UNDER;
							state_q <= S_OUT;
						end else begin
							a_q     <= top_q;
							state_q <= S_RD_A;
						end
					end
				end
				S_RD_A: state_q <= S_RD_B;
				S_RD_B: begin
					b_q     <= rd_data_q;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (op_q == OP_DIV[3:0]) begin
						if (b_q == '0) begin
							out_q.status <= ST_DIVZ;
							state_q <= S_OUT;
						end else begin
							quo_q   <= mag_a;
							rem_q   <= '0;
							b_q     <= mag_b;
							neg_q   <= sgn_q && (a_q[WORD_WIDTH-1] != b_q[WORD_WIDTH-1]);
							cnt_q   <= CW'(WORD_WIDTH);
							state_q <= S_DIV;
						end
					end else if (op_q == OP_MUL[3:0]) begin
						prod_q  <= a_q * b_q;
						state_q <= S_MUL;
					end else begin
						res_q   <= alu_res;
						sp_q    <= sp_q - PW'(1);
						state_q <= S_WB;
					end
				end
				S_MUL: begin
					res_q   <= prod_q;
					sp_q    <= sp_q - PW'(1);
					state_q <= S_WB;
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						res_q   <= neg_q ? -quo_q : quo_q;
						sp_q    <= sp_q - PW'(1);
						state_q <= S_WB;
					end else begin
						cnt_q <= cnt_q - CW'(1);
						if (!div_trial[WORD_WIDTH]) begin
							rem_q <= div_trial[WORD_WIDTH-1:0];
							quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b1};
						end else begin
							rem_q <= div_shift;
							quo_q <= {quo_q[WORD_WIDTH-2:0], 1'b0};
						end
					end
				end
				S_WB: begin
					top_q   <= res_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					out_valid_q       <= 1'b1;
					out_q.top_value   <= (sp_q == '0) ? 32'd0 : low32(top_q);
					out_q.stack_depth <= 9'(sp_q);
					state_q           <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
